FILE: hw/rtl/hmbd_pkg.sv
// types, codes and helpers shared by the message body deframer
package hmbd_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [0:0] {
    REG_BODY_MODE   = 1'b0,
    REG_BODY_LENGTH = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_FRAME  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  typedef enum logic [7:0] {
    CH_DIGIT0  = 8'b0000_0001,
    CH_DIGITS  = 8'b0000_0010,
    CH_SIZE_LF = 8'b0000_0100,
    CH_DATA    = 8'b0000_1000,
    CH_DATA_CR = 8'b0001_0000,
    CH_DATA_LF = 8'b0010_0000,
    CH_END_CR  = 8'b0100_0000,
    CH_END_LF  = 8'b1000_0000
  } chunk_step_t;

  typedef struct packed {
    logic        body_mode;
    logic [31:0] body_length;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    logic  header_end;
    logic  done_res;
    logic  status;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: hw/rtl/http_message_body_deframer.sv
// top level of the http message body deframer
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------------
//   in      | input     | in_valid/in_stall   | data_byte
//   out     | output    | out_valid/out_stall | out_byte, kind, header_end, done_res, status
//   cfg     | apb slave | psel/penable        | paddr, pwdata, prdata (body_mode, body_length)
//
// one request byte per cycle while in_stall is low; each byte is held in the input register
// while the framing state updates, then its result lands in the output register
// (out_valid rises once the byte has passed through the input register into the result register)
// rst is synchronous and returns the framing state to the header phase
// a stall on out holds the result and stalls in only when the input register is full
module http_message_body_deframer #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic [1:0]                    kind,
  output logic                          header_end,
  output logic                          done_res,
  output logic                          status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hmbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [hmbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [hmbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  hmbd_pkg::cfg_t    cfg;
  hmbd_pkg::result_t res;
  logic              in_q_valid;
  logic [7:0]        in_q_byte;
  logic              advance;
  logic              in_take;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  hmbd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hmbd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_q_byte),
    .cfg       (cfg),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= data_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= in_q_byte;
      kind       <= res.kind;
      header_end <= res.header_end;
      done_res   <= res.done_res;
      status     <= res.status;
    end
  end

endmodule

FILE: hw/rtl/hmbd_cfg_regs.sv
// apb register file for body mode and body length
module hmbd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hmbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [hmbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [hmbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output hmbd_pkg::cfg_t                cfg
);

  hmbd_pkg::reg_index_t idx;
  logic                 wr_en;

  assign idx    = hmbd_pkg::reg_index_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.body_mode   <= 1'b0;
      cfg.body_length <= 32'd0;
    end else if (wr_en) begin
      unique case (idx)
        hmbd_pkg::REG_BODY_MODE:   cfg.body_mode   <= pwdata[0];
        hmbd_pkg::REG_BODY_LENGTH: cfg.body_length <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hmbd_pkg::REG_BODY_MODE:   prdata = {31'd0, cfg.body_mode};
      hmbd_pkg::REG_BODY_LENGTH: prdata = cfg.body_length;
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/hmbd_parser.sv
// framing state and per-byte classification
module hmbd_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  hmbd_pkg::cfg_t      cfg,
  output hmbd_pkg::result_t   res
);

  hmbd_pkg::phase_t        phase, phase_next;
  hmbd_pkg::chunk_step_t   chunk_step, chunk_step_next;
  logic [1:0]              delimiter_match, delimiter_match_next;
  logic [LENGTH_BITS-1:0]  chunk_size_acc, chunk_size_acc_next;
  logic [LENGTH_BITS-1:0]  bytes_left, bytes_left_next;

  logic [63:0]             length_ext;
  logic [LENGTH_BITS-1:0]  length_latch;
  logic [7:0]              expect_byte;
  hmbd_pkg::hex_t          hex;
  logic                    bad;
  hmbd_pkg::kind_t         kind;
  logic                    hend;
  logic                    done;

  assign length_ext   = {32'd0, cfg.body_length};
  assign length_latch = length_ext[LENGTH_BITS-1:0];
  assign hex          = hmbd_pkg::hex_decode(data_byte);
  assign expect_byte  = delimiter_match[0] ? hmbd_pkg::CHAR_LF : hmbd_pkg::CHAR_CR;

  always_comb begin
    phase_next           = phase;
    chunk_step_next      = chunk_step;
    delimiter_match_next = delimiter_match;
    chunk_size_acc_next  = chunk_size_acc;
    bytes_left_next      = bytes_left;
    kind                 = hmbd_pkg::KIND_HEADER;
    hend                 = 1'b0;
    done                 = 1'b0;
    bad                  = 1'b0;

    unique case (phase)
      hmbd_pkg::PH_HEADER: begin
        if (data_byte == expect_byte) begin
          delimiter_match_next = delimiter_match + 2'd1;
          if (delimiter_match == 2'd3) begin
            // blank line seen, body starts
            hend                = 1'b1;
            phase_next          = hmbd_pkg::PH_BODY;
            chunk_step_next     = hmbd_pkg::CH_DIGIT0;
            chunk_size_acc_next = '0;
            bytes_left_next     = length_latch;
            if (!cfg.body_mode && length_latch == '0) begin
              done       = 1'b1;
              phase_next = hmbd_pkg::PH_DONE;
            end
          end
        end else if (data_byte == hmbd_pkg::CHAR_CR) begin
          delimiter_match_next = 2'd1;
        end else begin
          delimiter_match_next = 2'd0;
        end
      end

      hmbd_pkg::PH_BODY: begin
        if (!cfg.body_mode) begin
          if (bytes_left == '0) begin
            bad = 1'b1;
          end else begin
            kind            = hmbd_pkg::KIND_BODY;
            bytes_left_next = bytes_left - 1'b1;
            if (bytes_left == LENGTH_BITS'(1)) begin
              done       = 1'b1;
              phase_next = hmbd_pkg::PH_DONE;
            end
          end
        end else begin
          kind = hmbd_pkg::KIND_FRAME;
          unique case (chunk_step) inside
            hmbd_pkg::CH_DIGIT0, hmbd_pkg::CH_DIGITS: begin
              if (data_byte == hmbd_pkg::CHAR_CR && chunk_step == hmbd_pkg::CH_DIGITS) begin
                chunk_step_next = hmbd_pkg::CH_SIZE_LF;
              end else if (!hex.valid) begin
                bad = 1'b1;
              end else if (chunk_size_acc[LENGTH_BITS-1 -: 4] != 4'd0) begin
                // one more digit would overflow the size
                bad = 1'b1;
              end else begin
                chunk_size_acc_next = {chunk_size_acc[LENGTH_BITS-5:0], hex.value};
                chunk_step_next     = hmbd_pkg::CH_DIGITS;
              end
            end
            hmbd_pkg::CH_SIZE_LF: begin
              if (data_byte != hmbd_pkg::CHAR_LF) begin
                bad = 1'b1;
              end else if (chunk_size_acc == '0) begin
                chunk_step_next = hmbd_pkg::CH_END_CR;
              end else begin
                bytes_left_next = chunk_size_acc;
                chunk_step_next = hmbd_pkg::CH_DATA;
              end
            end
            hmbd_pkg::CH_DATA: begin
              kind = hmbd_pkg::KIND_BODY;
              if (bytes_left != '0) begin
                bytes_left_next = bytes_left - 1'b1;
              end
              if (bytes_left <= LENGTH_BITS'(1)) begin
                chunk_step_next = hmbd_pkg::CH_DATA_CR;
              end
            end
            hmbd_pkg::CH_DATA_CR: begin
              if (data_byte != hmbd_pkg::CHAR_CR) bad = 1'b1;
              else chunk_step_next = hmbd_pkg::CH_DATA_LF;
            end
            hmbd_pkg::CH_END_CR: begin
              if (data_byte != hmbd_pkg::CHAR_CR) bad = 1'b1;
              else chunk_step_next = hmbd_pkg::CH_END_LF;
            end
            hmbd_pkg::CH_DATA_LF: begin
              if (data_byte != hmbd_pkg::CHAR_LF) begin
                bad = 1'b1;
              end else begin
                chunk_size_acc_next = '0;
                chunk_step_next     = hmbd_pkg::CH_DIGIT0;
              end
            end
            hmbd_pkg::CH_END_LF: begin
              if (data_byte != hmbd_pkg::CHAR_LF) begin
                bad = 1'b1;
              end else begin
                done       = 1'b1;
                phase_next = hmbd_pkg::PH_DONE;
              end
            end
            default: bad = 1'b1;
          endcase
        end
      end

      default: bad = 1'b1;
    endcase

    if (bad) begin
      phase_next = hmbd_pkg::PH_FAIL;
      kind       = hmbd_pkg::KIND_REJECT;
      hend       = 1'b0;
      done       = 1'b0;
    end

    res.kind       = kind;
    res.header_end = hend;
    res.done_res   = done;
    res.status     = (phase_next == hmbd_pkg::PH_FAIL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hmbd_pkg::PH_HEADER;
      chunk_step      <= hmbd_pkg::CH_DIGIT0;
      delimiter_match <= 2'd0;
      chunk_size_acc  <= '0;
      bytes_left      <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      chunk_step      <= chunk_step_next;
      delimiter_match <= delimiter_match_next;
      chunk_size_acc  <= chunk_size_acc_next;
      bytes_left      <= bytes_left_next;
    end
  end

endmodule

FILE: tb/tb_top.sv
// testbench for the http message body deframer: byte stream stimulus with a built-in predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LEN_BITS    = 32;
  localparam int          ITEMS       = 1850;
  localparam int          PHASE_BYTES = 230;
  localparam int          CYCLE_LIMIT = 400_000;
  localparam logic [31:0] ACC_LIMIT   = 32'hFFFF_FFFF >> 4;

  typedef struct packed {
    logic [7:0]       data;
    hmbd_pkg::kind_t  kind;
    logic             header_end;
    logic             done_res;
    logic             status;
  } deframe_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic        header_end;
  logic        done_res;
  logic        status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [hmbd_pkg::PADDR_W-1:0] paddr = '0;
  logic [hmbd_pkg::PDATA_W-1:0] pwdata = '0;
  logic [hmbd_pkg::PDATA_W-1:0] prdata;
  logic        pready;

  http_message_body_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .kind(kind),
    .header_end(header_end), .done_res(done_res), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // request bytes waiting to be driven, and results still owed by the block
  logic [7:0]   req_bytes_q[$];
  deframe_res_t frame_res_q[$];
  int           n_pushed = 0;
  int           n_accepted = 0;
  int           err_count = 0;
  int           cycles = 0;
  int           idle_mode = 0;

  // shadow of the config registers and the framing state
  hmbd_pkg::cfg_t         cfg_shadow = '0;
  hmbd_pkg::phase_t       ph = hmbd_pkg::PH_HEADER;
  logic [2:0]             dmatch = 3'd0;
  hmbd_pkg::chunk_step_t  cstep = hmbd_pkg::CH_DIGIT0;
  logic [31:0]            size_acc = 32'd0;
  logic [31:0]            left = 32'd0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic deframe_res_t deframe_byte(input logic [7:0] c);
    deframe_res_t r;
    logic bad;
    int hv;
    r.data = c;
    r.kind = hmbd_pkg::KIND_HEADER;
    r.header_end = 1'b0;
    r.done_res = 1'b0;
    r.status = 1'b0;
    bad = 1'b0;
    case (ph)
      hmbd_pkg::PH_HEADER: begin
        if (c == (dmatch[0] ? hmbd_pkg::CHAR_LF : hmbd_pkg::CHAR_CR)) dmatch = dmatch + 3'd1;
        else if (c == hmbd_pkg::CHAR_CR) dmatch = 3'd1;
        else dmatch = 3'd0;
        if (dmatch == 3'd4) begin
          dmatch = 3'd0;
          r.header_end = 1'b1;
          ph = hmbd_pkg::PH_BODY;
          cstep = hmbd_pkg::CH_DIGIT0;
          size_acc = 32'd0;
          left = cfg_shadow.body_length;
          if (!cfg_shadow.body_mode && left == 32'd0) begin
            r.done_res = 1'b1;
            ph = hmbd_pkg::PH_DONE;
          end
        end
      end
      hmbd_pkg::PH_BODY: begin
        if (!cfg_shadow.body_mode) begin
          if (left == 32'd0) begin
            bad = 1'b1;
          end else begin
            r.kind = hmbd_pkg::KIND_BODY;
            left = left - 32'd1;
            if (left == 32'd0) begin
              r.done_res = 1'b1;
              ph = hmbd_pkg::PH_DONE;
            end
          end
        end else begin
          r.kind = hmbd_pkg::KIND_FRAME;
          case (cstep) inside
            hmbd_pkg::CH_DIGIT0, hmbd_pkg::CH_DIGITS: begin
              hv = hex_nibble(c);
              if (c == hmbd_pkg::CHAR_CR && cstep == hmbd_pkg::CH_DIGITS) begin
                cstep = hmbd_pkg::CH_SIZE_LF;
              end else if (hv < 0 || size_acc > ACC_LIMIT) begin
                bad = 1'b1;
              end else begin
                size_acc = {size_acc[27:0], hv[3:0]};
                cstep = hmbd_pkg::CH_DIGITS;
              end
            end
            hmbd_pkg::CH_SIZE_LF: begin
              if (c != hmbd_pkg::CHAR_LF) bad = 1'b1;
              else if (size_acc == 32'd0) cstep = hmbd_pkg::CH_END_CR;
              else begin
                left = size_acc;
                cstep = hmbd_pkg::CH_DATA;
              end
            end
            hmbd_pkg::CH_DATA: begin
              r.kind = hmbd_pkg::KIND_BODY;
              if (left != 32'd0) left = left - 32'd1;
              if (left == 32'd0) cstep = hmbd_pkg::CH_DATA_CR;
            end
            hmbd_pkg::CH_DATA_CR: begin
              if (c != hmbd_pkg::CHAR_CR) bad = 1'b1;
              else cstep = hmbd_pkg::CH_DATA_LF;
            end
            hmbd_pkg::CH_END_CR: begin
              if (c != hmbd_pkg::CHAR_CR) bad = 1'b1;
              else cstep = hmbd_pkg::CH_END_LF;
            end
            hmbd_pkg::CH_DATA_LF: begin
              if (c != hmbd_pkg::CHAR_LF) bad = 1'b1;
              else begin
                size_acc = 32'd0;
                cstep = hmbd_pkg::CH_DIGIT0;
              end
            end
            default: begin
              if (c != hmbd_pkg::CHAR_LF) bad = 1'b1;
              else begin
                r.done_res = 1'b1;
                ph = hmbd_pkg::PH_DONE;
              end
            end
          endcase
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      ph = hmbd_pkg::PH_FAIL;
      r.kind = hmbd_pkg::KIND_REJECT;
      r.header_end = 1'b0;
      r.done_res = 1'b0;
    end
    r.status = (ph == hmbd_pkg::PH_FAIL);
    return r;
  endfunction

  function automatic bit coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_res_q.push_back(deframe_byte(data_byte));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (req_bytes_q.size() != 0 &&
            !coin(idle_mode == 1 ? 67 : idle_mode == 3 ? 32 : 0)) begin
          in_valid <= 1'b1;
          data_byte <= req_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 10)
        $display("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin : result_mon
    deframe_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_res_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: byte %0h kind %0d", out_byte, kind);
        end else begin
          want = frame_res_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("kind", 8'(want.kind), 8'(kind));
          check_field("header_end", 8'(want.header_end), 8'(header_end));
          check_field("done_res", 8'(want.done_res), 8'(done_res));
          check_field("status", 8'(want.status), 8'(status));
        end
      end
      out_stall <= coin(idle_mode == 2 ? 67 : idle_mode == 3 ? 32 : 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(input hmbd_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == hmbd_pkg::REG_BODY_MODE) cfg_shadow.body_mode = val[0];
    else cfg_shadow.body_length = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (n_accepted != n_pushed || frame_res_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    req_bytes_q.push_back(b);
    n_pushed++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return 8'("0") + 8'(d);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == b);
    return c;
  endfunction

  task automatic push_size(input int unsigned sz, input int zeros);
    int nd;
    repeat (zeros) push_byte("0");
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    for (int i = nd - 1; i >= 0; i--) push_byte(hex_char(4'(sz >> (4 * i))));
  endtask

  task automatic push_chunk();
    int unsigned sz;
    sz = coin(10) ? $urandom_range(17, 80) : $urandom_range(1, 16);
    push_size(sz, coin(6) ? 8 : $urandom_range(0, 3));
    push_byte(hmbd_pkg::CHAR_CR);
    push_byte(hmbd_pkg::CHAR_LF);
    repeat (sz) push_byte(8'($urandom_range(0, 255)));
    push_byte(hmbd_pkg::CHAR_CR);
    push_byte(hmbd_pkg::CHAR_LF);
  endtask

  initial begin : stim
    logic [7:0]  hdr [11] = '{8'h47, 8'h00, 8'hFF, hmbd_pkg::CHAR_CR, hmbd_pkg::CHAR_LF,
                              hmbd_pkg::CHAR_CR, 8'h78, hmbd_pkg::CHAR_CR,
                              hmbd_pkg::CHAR_CR, hmbd_pkg::CHAR_LF, 8'h48};
    int unsigned scen, blen, n_body;
    logic        chunked;
    int          p, start;
    logic [7:0]  c;
    scen = $urandom_range(0, 13);
    chunked = (scen < 12);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    reg_write(hmbd_pkg::REG_BODY_MODE, 32'd0);
    reg_write(hmbd_pkg::REG_BODY_LENGTH, 32'hFFFF_FFFF);

    // header with partial and broken blank-line delimiters
    foreach (hdr[i]) push_byte(hdr[i]);
    wait_drained();
    blen = (scen == 12) ? 0 : (scen == 13) ? $urandom_range(1300, 1750) : $urandom;
    reg_write(hmbd_pkg::REG_BODY_MODE, {31'd0, chunked});
    reg_write(hmbd_pkg::REG_BODY_LENGTH, blen);
    push_byte(hmbd_pkg::CHAR_CR);
    push_byte(hmbd_pkg::CHAR_LF);
    push_byte(hmbd_pkg::CHAR_CR);
    push_byte(hmbd_pkg::CHAR_LF);
    if (chunked) begin
      push_size(1, 3);
      push_byte(hmbd_pkg::CHAR_CR);
      push_byte(hmbd_pkg::CHAR_LF);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(hmbd_pkg::CHAR_CR);
      push_byte(hmbd_pkg::CHAR_LF);
    end

    // body phases; body_length writes after the latch must not matter
    n_body = 0;
    p = 0;
    while (n_pushed < ITEMS) begin
      wait_drained();
      reg_write(hmbd_pkg::REG_BODY_LENGTH,
                (p % 3 == 0) ? 32'd0 : (p % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
      reg_write(hmbd_pkg::REG_BODY_MODE, {31'd0, chunked});
      idle_mode <= p % 4;
      start = n_pushed;
      while (n_pushed - start < PHASE_BYTES && n_pushed < ITEMS) begin
        if (chunked) begin
          push_chunk();
        end else begin
          push_byte(8'($urandom_range(0, 255)));
          if (n_body < blen) n_body++;
        end
      end
      p++;
    end

    wait_drained();
    case (scen) inside
      1: begin
        // switch to length mode inside a chunk: the rest of it is counted down
        push_size(5, 0);
        push_byte(hmbd_pkg::CHAR_CR);
        push_byte(hmbd_pkg::CHAR_LF);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        wait_drained();
        reg_write(hmbd_pkg::REG_BODY_MODE, 32'd0);
        repeat (3) push_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        push_byte("1");
        do c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0 || c == hmbd_pkg::CHAR_CR);
        push_byte(c);
      end
      3: push_byte(hmbd_pkg::CHAR_CR);
      4: begin
        // ninth significant digit overflows the size
        push_byte("1");
        repeat (8) push_byte(hex_char(4'($urandom_range(0, 15))));
      end
      5: begin
        push_byte("3");
        push_byte(hmbd_pkg::CHAR_CR);
        push_byte(byte_other_than(hmbd_pkg::CHAR_LF));
      end
      6, 7: begin
        push_byte("2");
        push_byte(hmbd_pkg::CHAR_CR);
        push_byte(hmbd_pkg::CHAR_LF);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        if (scen == 6) begin
          push_byte(byte_other_than(hmbd_pkg::CHAR_CR));
        end else begin
          push_byte(hmbd_pkg::CHAR_CR);
          push_byte(byte_other_than(hmbd_pkg::CHAR_LF));
        end
      end
      8, 9: begin
        push_byte("0");
        push_byte(hmbd_pkg::CHAR_CR);
        push_byte(hmbd_pkg::CHAR_LF);
        if (scen == 8) begin
          push_byte(byte_other_than(hmbd_pkg::CHAR_CR));
        end else begin
          push_byte(hmbd_pkg::CHAR_CR);
          push_byte(byte_other_than(hmbd_pkg::CHAR_LF));
        end
      end
      10: begin
        // length mode between chunks: no bytes left, so the next byte is rejected
        reg_write(hmbd_pkg::REG_BODY_MODE, 32'd0);
        push_byte(8'($urandom_range(0, 255)));
      end
      12, 13: ;
      default: begin
        push_size(0, $urandom_range(0, 2));
        push_byte(hmbd_pkg::CHAR_CR);
        push_byte(hmbd_pkg::CHAR_LF);
        push_byte(hmbd_pkg::CHAR_CR);
        push_byte(hmbd_pkg::CHAR_LF);
      end
    endcase

    // anything after completion or failure is rejected
    repeat (30) push_byte(8'($urandom_range(0, 255)));
    wait_drained();
    if (err_count == 0 && frame_res_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
